// ----- src/stt_pkg.sv -----
// Shared types and constants for the timer slot table.
// No dependencies; every other file imports this package.
package stt_pkg;

    // Input opcodes
    localparam logic [1:0] OP_TICK  = 2'd0;
    localparam logic [1:0] OP_START = 2'd1;
    localparam logic [1:0] OP_STOP  = 2'd2;

    // Result kinds
    localparam logic [1:0] RK_DONE   = 2'd0;
    localparam logic [1:0] RK_REJECT = 2'd1;
    localparam logic [1:0] RK_FIRED  = 2'd2;

    // At most this many fired words per tick
    localparam int MAX_FIRED = 8;
    localparam int CNT_W     = 4;

    // Command queue between front and back
    localparam int Q_DEPTH = 2;
    localparam int QPTR_W  = 1;
    localparam int QCNT_W  = 2;

    typedef struct packed {
        logic [1:0]  opcode;
        logic [3:0]  slot;
        logic [31:0] timeout_ms;
        logic        repeat_flag;
        logic [15:0] handler_line;
        logic [31:0] now_ms;
    } in_word_t;

    typedef struct packed {
        logic [1:0]  result_kind;
        logic [3:0]  fired_slot;
        logic [15:0] fired_line;
        logic        may_yield;
        logic        any_active;
        logic        last;
    } out_word_t;

    typedef enum logic [1:0] {
        CMD_TICK  = 2'd0,
        CMD_START = 2'd1,
        CMD_STOP  = 2'd2,
        CMD_NOP   = 2'd3
    } cmd_kind_t;

    // Classified command handed from front to back
    typedef struct packed {
        cmd_kind_t   kind;
        logic        slot_ok;
        logic [3:0]  slot;
        logic [15:0] line;
        logic [31:0] time_ms;   // due time for start, current time for tick
        logic [31:0] period;    // zero for the delay slot
        logic        repeat_on; // cleared for the delay slot
    } cmd_t;

endpackage

// ----- src/stt_front.sv -----
// Front end: accepts input words, classifies them and queues commands.
// Depends on stt_pkg.
module stt_front
    import stt_pkg::*;
#(
    parameter int NUM_SLOTS  = 8,
    parameter int DELAY_SLOT = 0
)
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     in_valid,
    output logic     in_ready,
    input  in_word_t in_word,
    output logic     cmd_valid,
    input  logic     cmd_ready,
    output cmd_t     cmd
);

    cmd_t              cls;
    logic              slot_ok;
    logic              is_delay;
    logic              push;
    logic              pop;
    cmd_t              q_mem [Q_DEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg;
    logic [QPTR_W-1:0] rd_ptr_reg;
    logic [QCNT_W-1:0] count_reg;
    logic [QCNT_W-1:0] count_next;

    // Classify the incoming word
    assign slot_ok  = {1'b0, in_word.slot} < 5'(NUM_SLOTS);
    assign is_delay = {1'b0, in_word.slot} == 5'(DELAY_SLOT);

    always_comb
    begin
        cls.slot_ok   = slot_ok;
        cls.slot      = in_word.slot;
        cls.line      = in_word.handler_line;
        cls.period    = is_delay ? 32'd0 : in_word.timeout_ms;
        cls.repeat_on = in_word.repeat_flag && !is_delay;
        cls.time_ms   = in_word.now_ms;
        unique case (in_word.opcode)
            OP_TICK:
            begin
                cls.kind = CMD_TICK;
            end
            OP_START:
            begin
                cls.kind    = CMD_START;
                cls.time_ms = in_word.now_ms + in_word.timeout_ms;
            end
            OP_STOP:
            begin
                cls.kind = CMD_STOP;
            end
            default:
            begin
                cls.kind = CMD_NOP;
            end
        endcase
    end

    // Command queue
    assign in_ready  = count_reg != QCNT_W'(Q_DEPTH);
    assign cmd_valid = count_reg != '0;
    assign push      = in_valid && in_ready;
    assign pop       = cmd_valid && cmd_ready;
    assign cmd       = q_mem[rd_ptr_reg];

    always_comb
    begin
        count_next = count_reg;
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            q_mem[wr_ptr_reg] <= cls;
        end
    end

    // Checks
    a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= QCNT_W'(Q_DEPTH))
        else $error("queue count out of range");

    a_push_grows: assert property (@(posedge clk) disable iff (!rst_n)
        push && !pop |=> count_reg == $past(count_reg) + 1'b1)
        else $error("queue push lost");

    a_ptr_gap: assert property (@(posedge clk) disable iff (!rst_n)
        (count_reg == '0 || count_reg == QCNT_W'(Q_DEPTH)) |-> wr_ptr_reg == rd_ptr_reg)
        else $error("queue pointers out of step");

endmodule

// ----- src/stt_back.sv -----
// Back end: holds the slot table, executes commands and scans slots on a tick.
// Depends on stt_pkg.
module stt_back
    import stt_pkg::*;
#(
    parameter int NUM_SLOTS  = 8,
    parameter int DELAY_SLOT = 0
)
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      cmd_valid,
    output logic      cmd_ready,
    input  cmd_t      cmd,
    output logic      out_valid,
    input  logic      out_ready,
    output out_word_t out_word
);

    localparam int SLOT_W = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;

    typedef enum logic [2:0] {
        ST_IDLE  = 3'b001,
        ST_SCAN  = 3'b010,
        ST_FLUSH = 3'b100
    } state_t;

    // Slot table; active bits stand in for a nonzero line
    logic [15:0]          line_mem   [NUM_SLOTS];
    logic [31:0]          due_mem    [NUM_SLOTS];
    logic [31:0]          period_mem [NUM_SLOTS];
    logic                 repeat_mem [NUM_SLOTS];
    logic [NUM_SLOTS-1:0] active_reg;
    logic [NUM_SLOTS-1:0] active_next;

    state_t               state_reg;
    state_t               state_next;
    logic [SLOT_W-1:0]    idx_reg;
    logic [SLOT_W-1:0]    idx_next;
    logic [CNT_W-1:0]     cnt_reg;
    logic [CNT_W-1:0]     cnt_next;
    logic [31:0]          now_reg;
    logic                 pend_valid_reg;
    logic                 pend_valid_next;
    out_word_t            pend_reg;
    logic                 out_valid_reg;
    logic                 out_valid_next;
    out_word_t            out_word_reg;

    logic                 can_move;
    logic                 cmd_take;
    logic [SLOT_W-1:0]    cmd_idx;
    logic [NUM_SLOTS-1:0] cmd_act;
    out_word_t            cmd_word;
    logic                 cur_delay;
    logic                 cur_keep;
    logic                 fire;
    logic                 fire_go;
    logic                 step;
    logic                 scan_last;
    logic [NUM_SLOTS-1:0] clr_mask;
    out_word_t            fire_word;
    out_word_t            flush_word;
    logic                 load_out;
    logic                 load_pend;
    out_word_t            out_load_word;

    assign can_move  = !out_valid_reg || out_ready;
    assign cmd_ready = (state_reg == ST_IDLE) && (cmd.kind == CMD_TICK || can_move);
    assign cmd_take  = cmd_valid && cmd_ready;
    assign cmd_idx   = cmd.slot[SLOT_W-1:0];

    // Active bits and result word of a start or stop
    always_comb
    begin
        cmd_act = active_reg;
        if (cmd.slot_ok)
        begin
            if (cmd.kind == CMD_START)
            begin
                cmd_act[cmd_idx] = cmd.line != 16'd0;
            end
            else if (cmd.kind == CMD_STOP)
            begin
                cmd_act[cmd_idx] = 1'b0;
            end
        end
        cmd_word             = '0;
        cmd_word.result_kind = (cmd.kind == CMD_START && !cmd.slot_ok) ? RK_REJECT : RK_DONE;
        cmd_word.any_active  = |cmd_act;
        cmd_word.last        = 1'b1;
    end

    // Evaluate the slot under the scan index
    assign cur_delay = {1'b0, 4'(idx_reg)} == 5'(DELAY_SLOT);
    assign cur_keep  = repeat_mem[idx_reg] && !cur_delay;
    assign fire      = active_reg[idx_reg] && (due_mem[idx_reg] <= now_reg);
    assign fire_go   = fire && (!pend_valid_reg || can_move);
    assign step      = !fire || fire_go;
    assign scan_last = (idx_reg == SLOT_W'(NUM_SLOTS - 1))
                    || (fire_go && cnt_reg == CNT_W'(MAX_FIRED - 1));

    always_comb
    begin
        clr_mask = '0;
        if (!cur_keep)
        begin
            clr_mask[idx_reg] = 1'b1;
        end
        fire_word             = '0;
        fire_word.result_kind = RK_FIRED;
        fire_word.fired_slot  = 4'(idx_reg);
        fire_word.fired_line  = line_mem[idx_reg];
        fire_word.may_yield   = !cur_delay;
        fire_word.any_active  = |(active_reg & ~clr_mask);
        fire_word.last        = 1'b0;

        if (pend_valid_reg)
        begin
            flush_word      = pend_reg;
            flush_word.last = 1'b1;
        end
        else
        begin
            flush_word            = '0;
            flush_word.result_kind = RK_DONE;
            flush_word.any_active = |active_reg;
            flush_word.last       = 1'b1;
        end
    end

    // Sequencer
    always_comb
    begin
        state_next      = state_reg;
        idx_next        = idx_reg;
        cnt_next        = cnt_reg;
        pend_valid_next = pend_valid_reg;
        out_valid_next  = out_valid_reg && !out_ready;
        active_next     = active_reg;
        load_out        = 1'b0;
        load_pend       = 1'b0;
        out_load_word   = cmd_word;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (cmd_take)
                begin
                    if (cmd.kind == CMD_TICK)
                    begin
                        state_next = ST_SCAN;
                        idx_next   = '0;
                        cnt_next   = '0;
                    end
                    else
                    begin
                        active_next    = cmd_act;
                        load_out       = 1'b1;
                        out_valid_next = 1'b1;
                    end
                end
            end
            ST_SCAN:
            begin
                if (step)
                begin
                    if (fire_go)
                    begin
                        active_next     = active_reg & ~clr_mask;
                        load_pend       = 1'b1;
                        pend_valid_next = 1'b1;
                        cnt_next        = cnt_reg + 1'b1;
                        if (pend_valid_reg)
                        begin
                            load_out       = 1'b1;
                            out_load_word  = pend_reg;
                            out_valid_next = 1'b1;
                        end
                    end
                    if (scan_last)
                    begin
                        state_next = ST_FLUSH;
                    end
                    else
                    begin
                        idx_next = idx_reg + 1'b1;
                    end
                end
            end
            ST_FLUSH:
            begin
                if (can_move)
                begin
                    load_out        = 1'b1;
                    out_load_word   = flush_word;
                    out_valid_next  = 1'b1;
                    pend_valid_next = 1'b0;
                    state_next      = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            idx_reg        <= '0;
            cnt_reg        <= '0;
            pend_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
            active_reg     <= '0;
        end
        else
        begin
            state_reg      <= state_next;
            idx_reg        <= idx_next;
            cnt_reg        <= cnt_next;
            pend_valid_reg <= pend_valid_next;
            out_valid_reg  <= out_valid_next;
            active_reg     <= active_next;
        end
    end

    // Payload registers and slot table
    always_ff @(posedge clk)
    begin
        if (load_out)
        begin
            out_word_reg <= out_load_word;
        end
        if (load_pend)
        begin
            pend_reg <= fire_word;
        end
        if (state_reg == ST_IDLE && cmd_take && cmd.kind == CMD_TICK)
        begin
            now_reg <= cmd.time_ms;
        end
        if (state_reg == ST_IDLE && cmd_take && cmd.kind == CMD_START && cmd.slot_ok)
        begin
            line_mem[cmd_idx]   <= cmd.line;
            due_mem[cmd_idx]    <= cmd.time_ms;
            period_mem[cmd_idx] <= cmd.period;
            repeat_mem[cmd_idx] <= cmd.repeat_on;
        end
        if (state_reg == ST_SCAN && fire_go && cur_keep)
        begin
            due_mem[idx_reg] <= due_mem[idx_reg] + period_mem[idx_reg];
        end
    end

    assign out_valid = out_valid_reg;
    assign out_word  = out_word_reg;

    // Checks
    a_state_onehot: assert property (@(posedge clk) disable iff (!rst_n)
        $onehot(state_reg))
        else $error("sequencer state not one-hot");

    a_pend_in_tick: assert property (@(posedge clk) disable iff (!rst_n)
        pend_valid_reg |-> state_reg != ST_IDLE)
        else $error("held fired word outside a tick");

    a_fire_cap: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg <= CNT_W'(MAX_FIRED))
        else $error("too many fired words in one tick");

    a_cmd_result: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_IDLE && cmd_take && cmd.kind != CMD_TICK
        |=> out_valid_reg && out_word_reg.last)
        else $error("command gave no final word");

    a_oneshot_clears: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_SCAN && fire_go && !cur_keep |=> !active_reg[$past(idx_reg)])
        else $error("one-shot slot still active after firing");

endmodule

// ----- src/software_timer_table_core.sv -----
// Top level of the timer slot table: front classifier/queue and back executor.
// Depends on stt_pkg, stt_front and stt_back.
//
//  channel | dir | handshake            | word
//  --------+-----+----------------------+-----------
//  in      | in  | in_valid / in_ready  | in_word_t
//  out     | out | out_valid / out_ready| out_word_t
//
// Start, stop and unused opcodes each give one word from the back end.
// A tick is accepted in idle, scans the slots in order from slot 0 and closes
// in the flush state with a final word; the scan ends early at MAX_FIRED words.
// A two-entry command queue lets the front keep taking words during a scan.
// Reset clears all active bits; slot contents need no clearing pass.
// A stalled output holds the scan on the next due slot until the word moves.
module software_timer_table_core
    import stt_pkg::*;
#(
    parameter int NUM_SLOTS  = 8,
    parameter int DELAY_SLOT = 0
)
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      in_valid,
    output logic      in_ready,
    input  in_word_t  in_word,
    output logic      out_valid,
    input  logic      out_ready,
    output out_word_t out_word
);

    logic cmd_valid;
    logic cmd_ready;
    cmd_t cmd;

    stt_front #(
        .NUM_SLOTS  (NUM_SLOTS),
        .DELAY_SLOT (DELAY_SLOT)
    ) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_word   (in_word),
        .cmd_valid (cmd_valid),
        .cmd_ready (cmd_ready),
        .cmd       (cmd)
    );

    stt_back #(
        .NUM_SLOTS  (NUM_SLOTS),
        .DELAY_SLOT (DELAY_SLOT)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_valid (cmd_valid),
        .cmd_ready (cmd_ready),
        .cmd       (cmd),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_word  (out_word)
    );

endmodule
